FILE: rtl/msnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnp_pkg
// Shared sizes, codes and record types of the MOESI snooping line controller.
// ----------------------------------------------------------------------------
package msnp_pkg;

    localparam int NUM_SETS = 64;
    localparam int NUM_WAYS = 4;

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ADDR_W = 32;

    // item kinds
    localparam logic [1:0] FUNC_PROC  = 2'd0;
    localparam logic [1:0] FUNC_SNOOP = 2'd1;
    localparam logic [1:0] FUNC_RESP  = 2'd2;

    // bus message kinds
    localparam logic [1:0] MSG_GETS = 2'd0;
    localparam logic [1:0] MSG_GETM = 2'd1;
    localparam logic [1:0] MSG_PUTM = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    // snoop acknowledgement codes
    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_PLAIN = 2'd1;
    localparam logic [1:0] ACK_MEM  = 2'd2;
    localparam logic [1:0] ACK_C2C  = 2'd3;

    typedef enum logic [2:0] {
        COH_I = 3'd0,
        COH_S = 3'd1,
        COH_E = 3'd2,
        COH_O = 3'd3,
        COH_M = 3'd4
    } coh_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        coh_t              coh;
        logic              occ;
    } line_t;

    // one set of the line store, with its replacement pointer
    typedef struct packed {
        line_t [NUM_WAYS-1:0] way;
        logic [WAY_W-1:0]     next_way;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] block_address;
        logic              write;
        logic [1:0]        msg_type;
        logic              from_self;
        logic              fill_source;
        logic              request_permitted;
        logic              victim_permitted;
    } item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic              accepted;
        logic              hit;
        logic [1:0]        send_type;
        logic [ADDR_W-1:0] address;
        logic [1:0]        snoop_ack;
        logic              last;
    } res_t;

endpackage

FILE: rtl/msnp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msnp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/msnp_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msnp_eval
// Lookup and MOESI update of one set row for one item; builds its results.
// ----------------------------------------------------------------------------
module msnp_eval (
    input  msnp_pkg::item_t       item,
    input  msnp_pkg::row_t        row,
    input  logic                  awaiting,
    output msnp_pkg::row_t        row_next,
    output msnp_pkg::res_t [1:0]  res,
    output logic                  res_two,
    output logic                  awaiting_next
);

    logic                        found;
    logic [msnp_pkg::WAY_W-1:0]  hit_way;
    logic [msnp_pkg::WAY_W-1:0]  vic;
    logic [msnp_pkg::WAY_W-1:0]  vic_adv;
    msnp_pkg::coh_t              hit_coh;
    msnp_pkg::line_t             vic_line;
    msnp_pkg::coh_t              fill;
    msnp_pkg::res_t              req_res;

    always_comb
    begin
        found   = 1'b0;
        hit_way = '0;
        // lowest matching way wins
        for (int w = msnp_pkg::NUM_WAYS - 1; w >= 0; w--)
        begin
            if (row.way[w].occ && row.way[w].addr == item.block_address)
            begin
                found   = 1'b1;
                hit_way = msnp_pkg::WAY_W'(w);
            end
        end
    end

    assign vic      = row.next_way;
    assign vic_adv  = (vic == msnp_pkg::WAY_W'(msnp_pkg::NUM_WAYS - 1)) ? '0 : vic + 1'b1;
    assign hit_coh  = row.way[hit_way].coh;
    assign vic_line = row.way[vic];
    assign fill     = (item.msg_type == msnp_pkg::MSG_GETM) ? msnp_pkg::COH_M :
                      (item.fill_source ? msnp_pkg::COH_E : msnp_pkg::COH_S);

    always_comb
    begin
        row_next      = row;
        res           = '0;
        res_two       = 1'b0;
        awaiting_next = awaiting;
        req_res       = '0;

        unique case (item.func)
            msnp_pkg::FUNC_PROC:
            begin
                if (awaiting || !item.request_permitted)
                begin
                    // refused, status only
                end
                else if (!found && !item.victim_permitted)
                begin
                    // victim not clear on the bus, refused
                end
                else if (found && hit_coh != msnp_pkg::COH_I)
                begin
                    res[0].accepted = 1'b1;
                    res[0].hit      = 1'b1;
                    if (item.write && hit_coh == msnp_pkg::COH_S)
                    begin
                        awaiting_next    = 1'b1;
                        res[0].kind      = msnp_pkg::KIND_REQUEST;
                        res[0].send_type = msnp_pkg::MSG_GETM;
                        res[0].address   = item.block_address;
                    end
                    else if (item.write &&
                             (hit_coh == msnp_pkg::COH_E || hit_coh == msnp_pkg::COH_O))
                    begin
                        row_next.way[hit_way].coh = msnp_pkg::COH_M;
                    end
                end
                else
                begin
                    if (!found && vic_line.occ)
                    begin
                        if (vic_line.coh == msnp_pkg::COH_S)
                        begin
                            row_next.way[vic].coh = msnp_pkg::COH_I;
                        end
                        else if (vic_line.coh == msnp_pkg::COH_E ||
                                 vic_line.coh == msnp_pkg::COH_M ||
                                 vic_line.coh == msnp_pkg::COH_O)
                        begin
                            res[0].kind      = msnp_pkg::KIND_REQUEST;
                            res[0].accepted  = 1'b1;
                            res[0].send_type = msnp_pkg::MSG_PUTM;
                            res[0].address   = vic_line.addr;
                            res_two          = 1'b1;
                        end
                    end
                    req_res.kind      = msnp_pkg::KIND_REQUEST;
                    req_res.accepted  = 1'b1;
                    req_res.send_type = item.write ? msnp_pkg::MSG_GETM : msnp_pkg::MSG_GETS;
                    req_res.address   = item.block_address;
                    if (res_two)
                    begin
                        res[1] = req_res;
                    end
                    else
                    begin
                        res[0] = req_res;
                    end
                    awaiting_next = 1'b1;
                end
            end

            msnp_pkg::FUNC_SNOOP:
            begin
                if (item.from_self)
                begin
                    if (item.msg_type == msnp_pkg::MSG_PUTM && found)
                    begin
                        res[0].snoop_ack = (hit_coh == msnp_pkg::COH_M ||
                                            hit_coh == msnp_pkg::COH_O) ?
                                           msnp_pkg::ACK_MEM : msnp_pkg::ACK_PLAIN;
                        row_next.way[hit_way].coh = msnp_pkg::COH_I;
                    end
                    else if (item.msg_type == msnp_pkg::MSG_PUTM ||
                             item.msg_type == msnp_pkg::MSG_GETM)
                    begin
                        res[0].snoop_ack = msnp_pkg::ACK_PLAIN;
                    end
                end
                else if (found && hit_coh != msnp_pkg::COH_I)
                begin
                    case (item.msg_type)
                        msnp_pkg::MSG_GETS:
                        begin
                            if (hit_coh == msnp_pkg::COH_M)
                            begin
                                row_next.way[hit_way].coh = msnp_pkg::COH_O;
                                res[0].snoop_ack          = msnp_pkg::ACK_C2C;
                            end
                            else if (hit_coh == msnp_pkg::COH_E)
                            begin
                                row_next.way[hit_way].coh = msnp_pkg::COH_S;
                                res[0].snoop_ack          = msnp_pkg::ACK_C2C;
                            end
                            else if (hit_coh == msnp_pkg::COH_O)
                            begin
                                res[0].snoop_ack = msnp_pkg::ACK_C2C;
                            end
                        end
                        msnp_pkg::MSG_GETM:
                        begin
                            res[0].snoop_ack = (hit_coh == msnp_pkg::COH_S) ?
                                               msnp_pkg::ACK_PLAIN : msnp_pkg::ACK_C2C;
                            row_next.way[hit_way].coh = msnp_pkg::COH_I;
                        end
                        default:
                        begin
                            // foreign PutM or unused code: no change
                        end
                    endcase
                end
                else if (item.msg_type == msnp_pkg::MSG_GETM)
                begin
                    res[0].snoop_ack = msnp_pkg::ACK_PLAIN;
                end
            end

            msnp_pkg::FUNC_RESP:
            begin
                if (!found)
                begin
                    if (vic_line.occ)
                    begin
                        res[0].kind    = msnp_pkg::KIND_RELEASE;
                        res[0].address = vic_line.addr;
                        res_two        = 1'b1;
                    end
                    row_next.way[vic].addr = item.block_address;
                    row_next.way[vic].coh  = fill;
                    row_next.way[vic].occ  = 1'b1;
                    row_next.next_way      = vic_adv;
                end
                else if (hit_coh == msnp_pkg::COH_I)
                begin
                    row_next.way[hit_way].coh = fill;
                end
                else
                begin
                    row_next.way[hit_way].coh = msnp_pkg::COH_M;
                end
                awaiting_next   = 1'b0;
                req_res.kind    = msnp_pkg::KIND_RELEASE;
                req_res.address = item.block_address;
                if (res_two)
                begin
                    res[1] = req_res;
                end
                else
                begin
                    res[0] = req_res;
                end
            end

            default:
            begin
                // unknown item kind: plain status
            end
        endcase

        if (res_two)
        begin
            res[1].last = 1'b1;
        end
        else
        begin
            res[0].last = 1'b1;
        end
    end

endmodule

FILE: rtl/moesi_snooping_line_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moesi_snooping_line_controller
// Snooping MOESI line controller over a set-associative store, FIFO victims.
// ----------------------------------------------------------------------------
// Each input transaction (processor request, snooped bus message, or response
// to this controller's own request) goes through an accept cycle and a lookup
// cycle: the accept cycle issues the read of the addressed set row from the
// line store RAM, and the lookup cycle compares the ways, applies the MOESI
// update, writes the whole row back and loads one or two results into the
// output queue. The next transaction is accepted in the cycle after the
// lookup, so no new transaction is taken before the last one is written back.
// Results leave one per cycle while result_stall is low; item_stall stays high
// outside the idle state, and a lookup waits while results of the previous
// transaction are still queued. Per-set valid bits stand in for the reset
// contents of the store, so there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module moesi_snooping_line_controller (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  func,
    input  logic [31:0] block_address,
    input  logic        write,
    input  logic [1:0]  msg_type,
    input  logic        from_self,
    input  logic        fill_source,
    input  logic        request_permitted,
    input  logic        victim_permitted,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic        accepted,
    output logic        hit,
    output logic [1:0]  send_type,
    output logic [31:0] address,
    output logic [1:0]  snoop_ack,
    output logic        last
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } state_t;

    state_t                          state_reg, state_next;
    logic [1:0]                      count_reg, count_next;
    msnp_pkg::res_t [1:0]            q_reg, q_next;
    logic                            awaiting_reg, awaiting_next;
    logic [msnp_pkg::NUM_SETS-1:0]   row_valid_reg, row_valid_next;
    logic                            rv_reg, rv_next;

    msnp_pkg::item_t                 item_reg;
    logic [msnp_pkg::SET_W-1:0]      set_reg;

    logic                            item_accept;
    logic                            result_accept;
    logic                            lookup_fire;
    logic [msnp_pkg::SET_W-1:0]      in_set;

    logic [msnp_pkg::ROW_W-1:0]      ram_rdata;
    msnp_pkg::row_t                  row_rd;
    msnp_pkg::row_t                  row_cur;
    msnp_pkg::row_t                  row_new;
    msnp_pkg::res_t [1:0]            ev_res;
    logic                            ev_two;
    logic                            ev_awaiting;

    // Handshakes
    assign item_stall    = (state_reg != ST_IDLE);
    assign item_accept   = item_valid && !item_stall;
    assign result_valid  = (count_reg != 2'd0);
    assign result_accept = result_valid && !result_stall;
    // lookup waits for the output queue to drain
    assign lookup_fire   = (state_reg == ST_LOOK) && (count_reg == 2'd0);

    assign in_set = msnp_pkg::SET_W'(block_address % msnp_pkg::NUM_SETS);

    // Line store: one row per set, read on accept, written back on lookup
    msnp_ram #(
        .DEPTH (msnp_pkg::NUM_SETS),
        .WIDTH (msnp_pkg::ROW_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (lookup_fire),
        .waddr (set_reg),
        .wdata (row_new),
        .re    (item_accept),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    assign row_rd = msnp_pkg::row_t'(ram_rdata);

    // A never-written set reads as empty: all ways unoccupied and invalid,
    // pointer at way 0. Addresses pass through since they are don't-care.
    always_comb
    begin
        row_cur = row_rd;
        if (!rv_reg)
        begin
            for (int w = 0; w < msnp_pkg::NUM_WAYS; w++)
            begin
                row_cur.way[w].coh = msnp_pkg::COH_I;
                row_cur.way[w].occ = 1'b0;
            end
            row_cur.next_way = '0;
        end
    end

    msnp_eval u_eval (
        .item          (item_reg),
        .row           (row_cur),
        .awaiting      (awaiting_reg),
        .row_next      (row_new),
        .res           (ev_res),
        .res_two       (ev_two),
        .awaiting_next (ev_awaiting)
    );

    // Sequencer and output queue
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        q_next         = q_reg;
        awaiting_next  = awaiting_reg;
        row_valid_next = row_valid_reg;
        rv_next        = rv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = ST_LOOK;
                    rv_next    = row_valid_reg[in_set];
                end
            end
            ST_LOOK:
            begin
                if (lookup_fire)
                begin
                    state_next              = ST_IDLE;
                    q_next                  = ev_res;
                    count_next              = ev_two ? 2'd2 : 2'd1;
                    awaiting_next           = ev_awaiting;
                    row_valid_next[set_reg] = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // never overlaps a lookup fire: that needs an empty queue
        if (result_accept)
        begin
            q_next[0]  = q_reg[1];
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 2'd0;
            q_reg         <= '0;
            awaiting_reg  <= 1'b0;
            row_valid_reg <= '0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            q_reg         <= q_next;
            awaiting_reg  <= awaiting_next;
            row_valid_reg <= row_valid_next;
            rv_reg        <= rv_next;
        end
    end

    // Transaction capture, payload only
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg.func              <= func;
            item_reg.block_address     <= block_address;
            item_reg.write             <= write;
            item_reg.msg_type          <= msg_type;
            item_reg.from_self         <= from_self;
            item_reg.fill_source       <= fill_source;
            item_reg.request_permitted <= request_permitted;
            item_reg.victim_permitted  <= victim_permitted;
            set_reg                    <= in_set;
        end
    end

    assign kind      = q_reg[0].kind;
    assign accepted  = q_reg[0].accepted;
    assign hit       = q_reg[0].hit;
    assign send_type = q_reg[0].send_type;
    assign address   = q_reg[0].address;
    assign snoop_ack = q_reg[0].snoop_ack;
    assign last      = q_reg[0].last;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output queue count out of range");

    a_fire_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_fire |=> result_valid)
        else $error("lookup produced no result");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> q_reg[0].last)
        else $error("final queued result lacks last");

    a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (!q_reg[0].last && q_reg[1].last))
        else $error("result pair has wrong last marks");

    a_resp_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (lookup_fire && item_reg.func == msnp_pkg::FUNC_RESP) |=> !awaiting_reg)
        else $error("response left request outstanding");
`endif

endmodule

FILE: dv/moesi_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moesi_line_checker
// Shadow of the MOESI line controller: watches both channels and checks results.
// ----------------------------------------------------------------------------
// Every accepted input transaction is run through a copy of the line store,
// which queues the results it should produce. Every accepted result is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module moesi_line_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  func,
    input  logic [31:0] block_address,
    input  logic        write,
    input  logic [1:0]  msg_type,
    input  logic        from_self,
    input  logic        fill_source,
    input  logic        request_permitted,
    input  logic        victim_permitted,

    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic        accepted,
    input  logic        hit,
    input  logic [1:0]  send_type,
    input  logic [31:0] address,
    input  logic [1:0]  snoop_ack,
    input  logic        last,

    output int          due_count,
    output int          fail_count
);

    localparam int NUM_LINES = msnp_pkg::NUM_SETS * msnp_pkg::NUM_WAYS;

    logic [msnp_pkg::ADDR_W-1:0] line_addr [NUM_LINES];
    msnp_pkg::coh_t              line_coh  [NUM_LINES];
    logic                        line_occ  [NUM_LINES];
    int                          next_way  [msnp_pkg::NUM_SETS];
    logic                        awaiting_fill;

    msnp_pkg::res_t results_due [$];
    int             errors;

    function automatic int find_line(input logic [msnp_pkg::ADDR_W-1:0] a);
        int set_idx;
        set_idx = int'(a % msnp_pkg::NUM_SETS);
        for (int w = 0; w < msnp_pkg::NUM_WAYS; w++)
        begin
            if (line_occ[set_idx * msnp_pkg::NUM_WAYS + w] &&
                line_addr[set_idx * msnp_pkg::NUM_WAYS + w] == a)
                return set_idx * msnp_pkg::NUM_WAYS + w;
        end
        return -1;
    endfunction

    function automatic msnp_pkg::res_t make_res(input logic [1:0] k, input logic acc,
                                                input logic h, input logic [1:0] st,
                                                input logic [msnp_pkg::ADDR_W-1:0] a,
                                                input logic [1:0] ack);
        msnp_pkg::res_t r;
        r.kind      = k;
        r.accepted  = acc;
        r.hit       = h;
        r.send_type = st;
        r.address   = a;
        r.snoop_ack = ack;
        r.last      = 1'b0;
        return r;
    endfunction

    // Applies one transaction to the shadow store and queues its results.
    task automatic coherence_step(input logic [1:0] f, input logic [msnp_pkg::ADDR_W-1:0] a,
                                  input logic wr, input logic [1:0] mt, input logic slf,
                                  input logic fs, input logic rp, input logic vp);
        msnp_pkg::res_t r [2];
        int             n;
        int             li;
        int             vi;
        int             set_idx;
        msnp_pkg::coh_t fill;
        logic [1:0]     ack;
        n       = 0;
        set_idx = int'(a % msnp_pkg::NUM_SETS);
        li      = find_line(a);
        vi      = set_idx * msnp_pkg::NUM_WAYS + next_way[set_idx];
        ack     = msnp_pkg::ACK_NONE;
        r[0]    = make_res(msnp_pkg::KIND_STATUS, 1'b0, 1'b0, msnp_pkg::MSG_GETS, '0,
                           msnp_pkg::ACK_NONE);
        r[1]    = r[0];
        case (f)
            msnp_pkg::FUNC_PROC:
            begin
                if (awaiting_fill || !rp || (li < 0 && !vp))
                    n = 1;
                else if (li >= 0 && line_coh[li] != msnp_pkg::COH_I)
                begin
                    if (wr && line_coh[li] == msnp_pkg::COH_S)
                    begin
                        awaiting_fill = 1'b1;
                        r[0] = make_res(msnp_pkg::KIND_REQUEST, 1'b1, 1'b1, msnp_pkg::MSG_GETM,
                                        a, msnp_pkg::ACK_NONE);
                    end
                    else
                    begin
                        if (wr && (line_coh[li] == msnp_pkg::COH_E ||
                                   line_coh[li] == msnp_pkg::COH_O))
                            line_coh[li] = msnp_pkg::COH_M;
                        r[0] = make_res(msnp_pkg::KIND_STATUS, 1'b1, 1'b1, msnp_pkg::MSG_GETS,
                                        '0, msnp_pkg::ACK_NONE);
                    end
                    n = 1;
                end
                else
                begin
                    if (li < 0 && line_occ[vi])
                    begin
                        if (line_coh[vi] == msnp_pkg::COH_S)
                            line_coh[vi] = msnp_pkg::COH_I;
                        else if (line_coh[vi] != msnp_pkg::COH_I)
                            r[n++] = make_res(msnp_pkg::KIND_REQUEST, 1'b1, 1'b0,
                                              msnp_pkg::MSG_PUTM, line_addr[vi],
                                              msnp_pkg::ACK_NONE);
                    end
                    r[n++] = make_res(msnp_pkg::KIND_REQUEST, 1'b1, 1'b0,
                                      wr ? msnp_pkg::MSG_GETM : msnp_pkg::MSG_GETS,
                                      a, msnp_pkg::ACK_NONE);
                    awaiting_fill = 1'b1;
                end
            end
            msnp_pkg::FUNC_SNOOP:
            begin
                if (slf)
                begin
                    if (mt == msnp_pkg::MSG_PUTM && li >= 0)
                    begin
                        ack = (line_coh[li] == msnp_pkg::COH_M ||
                               line_coh[li] == msnp_pkg::COH_O) ?
                              msnp_pkg::ACK_MEM : msnp_pkg::ACK_PLAIN;
                        line_coh[li] = msnp_pkg::COH_I;
                    end
                    else if (mt == msnp_pkg::MSG_PUTM || mt == msnp_pkg::MSG_GETM)
                        ack = msnp_pkg::ACK_PLAIN;
                end
                else if (li >= 0 && line_coh[li] != msnp_pkg::COH_I)
                begin
                    if (mt == msnp_pkg::MSG_GETS)
                    begin
                        if (line_coh[li] == msnp_pkg::COH_M)
                        begin
                            line_coh[li] = msnp_pkg::COH_O;
                            ack = msnp_pkg::ACK_C2C;
                        end
                        else if (line_coh[li] == msnp_pkg::COH_E)
                        begin
                            line_coh[li] = msnp_pkg::COH_S;
                            ack = msnp_pkg::ACK_C2C;
                        end
                        else if (line_coh[li] == msnp_pkg::COH_O)
                            ack = msnp_pkg::ACK_C2C;
                    end
                    else if (mt == msnp_pkg::MSG_GETM)
                    begin
                        ack = (line_coh[li] == msnp_pkg::COH_S) ?
                              msnp_pkg::ACK_PLAIN : msnp_pkg::ACK_C2C;
                        line_coh[li] = msnp_pkg::COH_I;
                    end
                end
                else if (mt == msnp_pkg::MSG_GETM)
                    ack = msnp_pkg::ACK_PLAIN;
                r[0] = make_res(msnp_pkg::KIND_STATUS, 1'b0, 1'b0, msnp_pkg::MSG_GETS, '0, ack);
                n = 1;
            end
            msnp_pkg::FUNC_RESP:
            begin
                fill = (mt == msnp_pkg::MSG_GETM) ? msnp_pkg::COH_M :
                       (fs ? msnp_pkg::COH_E : msnp_pkg::COH_S);
                if (li < 0)
                begin
                    if (line_occ[vi])
                        r[n++] = make_res(msnp_pkg::KIND_RELEASE, 1'b0, 1'b0, msnp_pkg::MSG_GETS,
                                          line_addr[vi], msnp_pkg::ACK_NONE);
                    line_addr[vi] = a;
                    line_coh[vi]  = fill;
                    line_occ[vi]  = 1'b1;
                    next_way[set_idx] = (next_way[set_idx] + 1) % msnp_pkg::NUM_WAYS;
                end
                else if (line_coh[li] == msnp_pkg::COH_I)
                    line_coh[li] = fill;
                else
                    line_coh[li] = msnp_pkg::COH_M;
                awaiting_fill = 1'b0;
                r[n++] = make_res(msnp_pkg::KIND_RELEASE, 1'b0, 1'b0, msnp_pkg::MSG_GETS, a,
                                  msnp_pkg::ACK_NONE);
            end
            default:
                n = 1;
        endcase
        r[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            results_due.push_back(r[i]);
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        msnp_pkg::res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LINES; i++)
            begin
                line_addr[i] = '0;
                line_coh[i]  = msnp_pkg::COH_I;
                line_occ[i]  = 1'b0;
            end
            for (int s = 0; s < msnp_pkg::NUM_SETS; s++)
                next_way[s] = 0;
            awaiting_fill = 1'b0;
            results_due.delete();
            errors = 0;
            due_count  <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                coherence_step(func, block_address, write, msg_type, from_self,
                               fill_source, request_permitted, victim_permitted);
            if (result_valid && !result_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with nothing outstanding: kind %0d address 0x%0h",
                           kind, address);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(kind));
                    compare_field("accepted", 32'(want.accepted), 32'(accepted));
                    compare_field("hit", 32'(want.hit), 32'(hit));
                    compare_field("send_type", 32'(want.send_type), 32'(send_type));
                    compare_field("address", want.address, address);
                    compare_field("snoop_ack", 32'(want.snoop_ack), 32'(snoop_ack));
                    compare_field("last", 32'(want.last), 32'(last));
                end
            end
            due_count  <= results_due.size();
            fail_count <= errors;
        end
    end

endmodule

FILE: dv/tb_moesi_snooping_line_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moesi_snooping_line_controller
// Stimulus and verdict for the MOESI snooping line controller.
// ----------------------------------------------------------------------------
// A directed sequence walks the MOESI transitions, refusals and evictions,
// then random request/fill sequences over a small pool of colliding addresses
// mixed with snoops and noise. Sender bursts and receiver stalls are random;
// the checker beside the DUT does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_moesi_snooping_line_controller;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_SIZE    = 18;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        item_valid;
    logic        item_stall;
    logic [1:0]  func;
    logic [31:0] block_address;
    logic        write;
    logic [1:0]  msg_type;
    logic        from_self;
    logic        fill_source;
    logic        request_permitted;
    logic        victim_permitted;

    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  kind;
    logic        accepted;
    logic        hit;
    logic [1:0]  send_type;
    logic [31:0] address;
    logic [1:0]  snoop_ack;
    logic        last;

    int          due_count;
    int          fail_count;
    int          cycle_count = 0;

    // sender burst bookkeeping
    int          burst_left = 0;
    int          items_sent = 0;

    // receiver stall pattern
    int          stall_mode = 0;
    int          stall_phase_left = 0;

    // addresses that collide in three sets, so hits, upgrades and
    // evictions keep happening
    logic [31:0] addr_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    moesi_snooping_line_controller i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .func              (func),
        .block_address     (block_address),
        .write             (write),
        .msg_type          (msg_type),
        .from_self         (from_self),
        .fill_source       (fill_source),
        .request_permitted (request_permitted),
        .victim_permitted  (victim_permitted),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .kind              (kind),
        .accepted          (accepted),
        .hit               (hit),
        .send_type         (send_type),
        .address           (address),
        .snoop_ack         (snoop_ack),
        .last              (last)
    );

    moesi_line_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .func              (func),
        .block_address     (block_address),
        .write             (write),
        .msg_type          (msg_type),
        .from_self         (from_self),
        .fill_source       (fill_source),
        .request_permitted (request_permitted),
        .victim_permitted  (victim_permitted),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .kind              (kind),
        .accepted          (accepted),
        .hit               (hit),
        .send_type         (send_type),
        .address           (address),
        .snoop_ack         (snoop_ack),
        .last              (last),
        .due_count         (due_count),
        .fail_count        (fail_count)
    );

    // Receiver: phases of no stall, coin-flip stall, heavy stall and a
    // periodic pattern, each lasting a random number of cycles.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (stall_phase_left == 0)
        begin
            stall_mode       <= $urandom_range(0, 3);
            stall_phase_left <= $urandom_range(10, 80);
        end
        else
            stall_phase_left <= stall_phase_left - 1;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= 1'($urandom_range(0, 1));
            2:       result_stall <= ($urandom_range(0, 4) != 0);
            default: result_stall <= (cycle_count % 7 < 3);
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Drives one transaction at a rising edge and holds it until taken.
    // Afterwards the burst counter decides whether valid drops for a gap.
    task automatic issue(input logic [1:0] f, input logic [31:0] a, input logic wr,
                         input logic [1:0] mt, input logic slf, input logic fs,
                         input logic rp, input logic vp);
        item_valid        <= 1'b1;
        func              <= f;
        block_address     <= a;
        write             <= wr;
        msg_type          <= mt;
        from_self         <= slf;
        fill_source       <= fs;
        request_permitted <= rp;
        victim_permitted  <= vp;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge clk);
            // mostly short bursts, now and then a long back-to-back run
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    // The first edge lets the checker's count catch up with the last accept.
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    initial
    begin
        logic [31:0] a;
        logic        wr;
        int          sel;
        int          mid_set;

        rst_n             = 1'b0;
        item_valid        = 1'b0;
        func              = msnp_pkg::FUNC_PROC;
        block_address     = '0;
        write             = 1'b0;
        msg_type          = msnp_pkg::MSG_GETS;
        from_self         = 1'b0;
        fill_source       = 1'b0;
        request_permitted = 1'b0;
        victim_permitted  = 1'b0;

        // six addresses per set in sets 0, 63 and one random middle set;
        // upper bits random, with all-zero and all-one tags included
        mid_set = $urandom_range(1, msnp_pkg::NUM_SETS - 2);
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            sel = (i % 3 == 0) ? 0 : ((i % 3 == 1) ? msnp_pkg::NUM_SETS - 1 : mid_set);
            addr_pool[i] = ($urandom() & ~32'(msnp_pkg::NUM_SETS - 1)) | 32'(sel);
        end
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed walk through the protocol -------------------------
        // read miss, then a request while the fill is still outstanding
        issue(msnp_pkg::FUNC_PROC,  32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        issue(msnp_pkg::FUNC_PROC,  32'h40, 1'b1, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        // memory fill gives E; a write hit upgrades silently to M
        issue(msnp_pkg::FUNC_RESP,  32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b1, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_PROC,  32'h0, 1'b1, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        // foreign GetS: M to O with data, O stays O with data
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b0, 1'b0);
        // write hit on O goes to M, foreign GetM invalidates
        issue(msnp_pkg::FUNC_PROC,  32'h0, 1'b1, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_GETM, 1'b0, 1'b0, 1'b0, 1'b0);
        // line present but invalid: re-requested without a victim check
        issue(msnp_pkg::FUNC_PROC,  32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b0);
        issue(msnp_pkg::FUNC_RESP,  32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b0, 1'b0);
        // write on S sends GetM; the fill upgrades S to M
        issue(msnp_pkg::FUNC_PROC,  32'h0, 1'b1, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        issue(msnp_pkg::FUNC_RESP,  32'h0, 1'b0, msnp_pkg::MSG_GETM, 1'b0, 1'b0, 1'b0, 1'b0);
        // bus refuses the address, then the victim
        issue(msnp_pkg::FUNC_PROC,  32'hFFFF_FFFF, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0,
              1'b0, 1'b1);
        issue(msnp_pkg::FUNC_PROC,  32'hFFFF_FFFF, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0,
              1'b1, 1'b0);
        // own messages seen on the bus
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_PUTM, 1'b1, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_SNOOP, 32'h40, 1'b0, msnp_pkg::MSG_PUTM, 1'b1, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_GETS, 1'b1, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_GETM, 1'b1, 1'b0, 1'b0, 1'b0);
        // foreign PutM and the unused message code do nothing
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, msnp_pkg::MSG_PUTM, 1'b0, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_SNOOP, 32'h0, 1'b0, 2'd3, 1'b0, 1'b0, 1'b0, 1'b0);
        // unknown item kind, all other fields high
        issue(2'd3, 32'hFFFF_FFFF, 1'b1, 2'd3, 1'b1, 1'b1, 1'b1, 1'b1);
        // foreign GetM with no line
        issue(msnp_pkg::FUNC_SNOOP, 32'hFFFF_FFFF, 1'b0, msnp_pkg::MSG_GETM, 1'b0, 1'b0,
              1'b0, 1'b0);
        // unsolicited fills load all four ways of set 63 (M, E, S, E)
        issue(msnp_pkg::FUNC_RESP,  32'hFFFF_FFFF, 1'b0, msnp_pkg::MSG_GETM, 1'b0, 1'b0,
              1'b0, 1'b0);
        issue(msnp_pkg::FUNC_RESP,  32'h3F, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b1, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_RESP,  32'h7F, 1'b0, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b0, 1'b0);
        issue(msnp_pkg::FUNC_RESP,  32'hBF, 1'b0, 2'd3, 1'b0, 1'b1, 1'b0, 1'b0);
        // write miss evicts the M way: PutM then GetM; the fill releases both
        issue(msnp_pkg::FUNC_PROC,  32'hFF, 1'b1, msnp_pkg::MSG_GETS, 1'b0, 1'b0, 1'b1, 1'b1);
        issue(msnp_pkg::FUNC_RESP,  32'hFF, 1'b0, msnp_pkg::MSG_GETM, 1'b0, 1'b0, 1'b0, 1'b0);

        // quiet point: every directed result must be back before going on
        drain();

        // ---- random part ------------------------------------------------
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                // request with its fill, sometimes with a snoop in between
                a  = pick_addr();
                wr = 1'($urandom_range(0, 1));
                issue(msnp_pkg::FUNC_PROC, a, wr, 2'($urandom()), 1'($urandom()),
                      1'($urandom()), $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
                if ($urandom_range(0, 9) < 3)
                    issue(msnp_pkg::FUNC_SNOOP, pick_addr(), 1'($urandom()),
                          2'($urandom_range(0, 3)), $urandom_range(0, 4) == 0,
                          1'($urandom()), 1'($urandom()), 1'($urandom()));
                if ($urandom_range(0, 19) != 0)
                    issue(msnp_pkg::FUNC_RESP, a, 1'($urandom()),
                          wr ? msnp_pkg::MSG_GETM : msnp_pkg::MSG_GETS,
                          1'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
            end
            else if (sel < 85)
                issue(msnp_pkg::FUNC_SNOOP, pick_addr(), 1'($urandom()),
                      2'($urandom_range(0, 3)), $urandom_range(0, 4) == 0,
                      1'($urandom()), 1'($urandom()), 1'($urandom()));
            else if (sel < 95)
                issue(msnp_pkg::FUNC_RESP, pick_addr(), 1'($urandom()),
                      2'($urandom_range(0, 3)), 1'($urandom()), 1'($urandom()),
                      1'($urandom()), 1'($urandom()));
            else
                issue(2'($urandom_range(0, 3)), $urandom(), 1'($urandom()), 2'($urandom()),
                      1'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
            if ($urandom_range(0, 199) == 0)
                drain();
        end

        // ---- wind down --------------------------------------------------
        drain();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
rtl/msnp_pkg.sv
rtl/msnp_ram.sv
rtl/msnp_eval.sv
rtl/moesi_snooping_line_controller.sv
dv/moesi_line_checker.sv
dv/tb_moesi_snooping_line_controller.sv
